[rtl/core/lmet_pkg.sv]
// shared types, constants and line arithmetic for the min line envelope tree
`timescale 1ns / 1ps

package lmet_pkg;

    localparam logic signed [63:0] FLAT_LEVEL = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MIN    = 64'sh8000_0000_0000_0000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // width of one stored node: valid, slope, intercept
    localparam int ENTRY_W = 97;

    // item traveling down the chain of level cells
    typedef struct packed {
        logic               op;
        logic signed [31:0] slope;
        logic signed [63:0] icpt;
        logic signed [32:0] lo;
        logic signed [32:0] x;
        logic signed [63:0] best;
    } lmet_tok_t;

    // end of a walk, reported by whichever cell finishes it
    typedef struct packed {
        logic               done;
        logic               query;
        logic signed [63:0] best;
    } lmet_done_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MLO,
        C_MMID,
        C_AMID,
        C_FIN
    } lmet_cell_state_t;

    typedef enum logic [1:0] {
        T_CLEAR,
        T_IDLE,
        T_BUSY
    } lmet_top_state_t;

    // product plus intercept, clamped to signed 64 bits
    function automatic logic signed [63:0] lmet_sat_add(input logic signed [64:0] p,
                                                        input logic signed [63:0] c);
        logic signed [65:0] s;
        begin
            s = {p[64], p} + {{2{c[63]}}, c};
            if (s[65:63] == 3'b000 || s[65:63] == 3'b111) begin
                return s[63:0];
            end else if (s[65]) begin
                return VAL_MIN;
            end else begin
                return VAL_MAX;
            end
        end
    endfunction

endpackage

[rtl/core/lmet_ram.sv]
// generic simple dual port ram, registered read
`timescale 1ns / 1ps

module lmet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/lmet_cell.sv]
// one tree level: node store, line evaluation, swap and hand-off to the next level
`timescale 1ns / 1ps

module lmet_cell #(
    parameter int DB    = 10,
    parameter int LEVEL = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clr_en,
    input  logic [DB-1:0]         clr_addr,
    input  logic                  in_vld,
    input  lmet_pkg::lmet_tok_t   in_tok,
    input  logic [DB-1:0]         in_idx,
    output logic                  out_vld,
    output lmet_pkg::lmet_tok_t   out_tok,
    output logic [DB-1:0]         out_idx,
    output lmet_pkg::lmet_done_t  done_o
);

    localparam int  HALF = (1 << (DB - LEVEL)) / 2;
    localparam logic signed [32:0] HALF_W = 33'(HALF);
    localparam bit  LAST = (LEVEL == DB);

    lmet_pkg::lmet_cell_state_t st_reg, st_next;
    lmet_pkg::lmet_tok_t tok_reg, tok_next;
    logic [DB-1:0] idx_reg, idx_next;
    logic signed [64:0] pn_reg, pn_next, po_reg, po_next;
    logic signed [63:0] vnl_reg, vnl_next, vol_reg, vol_next;
    logic signed [63:0] vnm_reg, vnm_next, vom_reg, vom_next;
    logic ll_reg, ll_next;

    logic               ent_valid;
    logic signed [31:0] ent_slope;
    logic signed [63:0] ent_icpt;
    logic               wr_en;
    logic               mid_lower;
    logic               dir;
    logic signed [32:0] mid;
    logic signed [32:0] mult_pt;
    logic signed [64:0] a_new, a_old, b_pt;

    // node store of this level
    if (LEVEL == 0) begin : g_root
        logic signed [31:0] root_slope_reg;
        logic signed [63:0] root_icpt_reg;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                root_slope_reg <= '0;
                root_icpt_reg  <= lmet_pkg::FLAT_LEVEL;
            end else if (wr_en) begin
                root_slope_reg <= tok_reg.slope;
                root_icpt_reg  <= tok_reg.icpt;
            end
        end
        assign ent_valid = 1'b1;
        assign ent_slope = root_slope_reg;
        assign ent_icpt  = root_icpt_reg;
    end else begin : g_mem
        logic [lmet_pkg::ENTRY_W-1:0] rdata;
        logic [lmet_pkg::ENTRY_W-1:0] wdata;
        logic [LEVEL-1:0]             waddr, raddr;
        assign wdata = clr_en ? '0 : {1'b1, tok_reg.slope, tok_reg.icpt};
        assign waddr = clr_en ? clr_addr[LEVEL-1:0] : idx_reg[LEVEL-1:0];
        assign raddr = (st_reg == lmet_pkg::C_IDLE) ? in_idx[LEVEL-1:0]
                                                    : idx_reg[LEVEL-1:0];
        lmet_ram #(
            .WIDTH (lmet_pkg::ENTRY_W),
            .DEPTH (1 << LEVEL)
        ) u_ram (
            .aclk  (aclk),
            .we    (clr_en | wr_en),
            .waddr (waddr),
            .wdata (wdata),
            .raddr (raddr),
            .rdata (rdata)
        );
        assign ent_valid = rdata[96];
        assign ent_slope = rdata[95:64];
        assign ent_icpt  = rdata[63:0];
    end

    assign mid     = tok_reg.lo + HALF_W;
    assign mult_pt = (tok_reg.op == lmet_pkg::OP_QUERY) ? tok_reg.x
                   : ((st_reg == lmet_pkg::C_MLO) ? tok_reg.lo : mid);
    assign a_new   = {{33{tok_reg.slope[31]}}, tok_reg.slope};
    assign a_old   = {{33{ent_slope[31]}}, ent_slope};
    assign b_pt    = {{32{mult_pt[32]}}, mult_pt};
    assign mid_lower = vnm_reg < vom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= lmet_pkg::C_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
        idx_reg <= idx_next;
        pn_reg  <= pn_next;
        po_reg  <= po_next;
        vnl_reg <= vnl_next;
        vol_reg <= vol_next;
        vnm_reg <= vnm_next;
        vom_reg <= vom_next;
        ll_reg  <= ll_next;
    end

    always_comb begin
        st_next  = st_reg;
        tok_next = tok_reg;
        idx_next = idx_reg;
        pn_next  = pn_reg;
        po_next  = po_reg;
        vnl_next = vnl_reg;
        vol_next = vol_reg;
        vnm_next = vnm_reg;
        vom_next = vom_reg;
        ll_next  = ll_reg;
        wr_en    = 1'b0;
        dir      = 1'b0;
        out_vld  = 1'b0;
        out_tok  = tok_reg;
        out_idx  = idx_reg;
        done_o   = '{done: 1'b0, query: tok_reg.op, best: tok_reg.best};
        unique case (st_reg)
            lmet_pkg::C_IDLE: begin
                if (in_vld) begin
                    tok_next = in_tok;
                    idx_next = in_idx;
                    st_next  = lmet_pkg::C_MLO;
                end
            end
            lmet_pkg::C_MLO: begin
                if (!ent_valid) begin
                    // empty node: an insert settles here, a query ends here
                    wr_en       = (tok_reg.op == lmet_pkg::OP_INSERT);
                    done_o.done = 1'b1;
                    st_next     = lmet_pkg::C_IDLE;
                end else begin
                    pn_next = a_new * b_pt;
                    po_next = a_old * b_pt;
                    st_next = lmet_pkg::C_MMID;
                end
            end
            lmet_pkg::C_MMID: begin
                vnl_next = lmet_pkg::lmet_sat_add(pn_reg, tok_reg.icpt);
                vol_next = lmet_pkg::lmet_sat_add(po_reg, ent_icpt);
                pn_next  = a_new * b_pt;
                po_next  = a_old * b_pt;
                st_next  = lmet_pkg::C_AMID;
            end
            lmet_pkg::C_AMID: begin
                vnm_next = lmet_pkg::lmet_sat_add(pn_reg, tok_reg.icpt);
                vom_next = lmet_pkg::lmet_sat_add(po_reg, ent_icpt);
                ll_next  = vnl_reg < vol_reg;
                st_next  = lmet_pkg::C_FIN;
            end
            lmet_pkg::C_FIN: begin
                st_next = lmet_pkg::C_IDLE;
                if (tok_reg.op == lmet_pkg::OP_QUERY) begin
                    if (vom_reg < tok_reg.best) begin
                        out_tok.best = vom_reg;
                    end
                    dir = !(tok_reg.x < mid);
                end else begin
                    // keep the line lower at mid, carry the other one down
                    if (mid_lower) begin
                        wr_en         = 1'b1;
                        out_tok.slope = ent_slope;
                        out_tok.icpt  = ent_icpt;
                    end
                    dir = (ll_reg == mid_lower);
                end
                if (dir) begin
                    out_tok.lo = mid;
                end
                out_idx = DB'({idx_reg, dir});
                if (LAST) begin
                    done_o.done = 1'b1;
                    done_o.best = out_tok.best;
                end else begin
                    out_vld = 1'b1;
                end
            end
            default: begin
                st_next = lmet_pkg::C_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/min_line_envelope_tree_unit.sv]
// top level of the min line envelope tree: chain of level cells, clear pass, item control
`timescale 1ns / 1ps

//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  config  | cfg_wr_en, cfg_wr_data (x_base)                 | in
//  input   | s_valid/s_ready, s_op, s_line_slope,            | in
//          | s_line_intercept, s_query_x                     |
//  result  | m_valid/m_ready, m_min_value, m_out_of_domain   | out
//
// one item at a time walks the cells from the root; each level steps through
// multiply at left end, multiply at midpoint, saturating adds, compare and
// write back; a walk that reaches an empty node ends in that level's first
// step. an out of domain query answers in the cycle after it is accepted,
// without entering the chain. after reset a clearing pass empties every
// level below the root; s_ready stays low meanwhile, config writes are taken.
// s_ready is low while a walk is in flight or a result waits for m_ready.

module min_line_envelope_tree_unit #(
    parameter int DOMAIN_BITS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_line_slope,
    input  logic signed [63:0] s_line_intercept,
    input  logic signed [31:0] s_query_x,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_min_value,
    output logic               m_out_of_domain
);

    localparam int DB = DOMAIN_BITS;
    localparam logic signed [32:0] SPAN_M1 = 33'((1 << DB) - 1);

    lmet_pkg::lmet_top_state_t state_reg, state_next;
    logic [DB-1:0]      clr_cnt_reg, clr_cnt_next;
    logic signed [31:0] x_base_reg;
    logic               m_valid_reg, m_valid_next;
    logic signed [63:0] m_value_reg, m_value_next;
    logic               m_ood_reg, m_ood_next;

    // chain wiring, one slot per level plus the spill past the last cell
    logic                 vld_w [0:DB+1];
    lmet_pkg::lmet_tok_t  tok_w [0:DB+1];
    logic [DB-1:0]        idx_w [0:DB+1];
    lmet_pkg::lmet_done_t done_w [0:DB];
    lmet_pkg::lmet_done_t done_any;

    logic               accept;
    logic signed [32:0] x_ext, base_ext;
    logic               ood;

    assign x_ext    = {s_query_x[31], s_query_x};
    assign base_ext = {x_base_reg[31], x_base_reg};
    assign ood      = (x_ext < base_ext) || (x_ext > base_ext + SPAN_M1);

    assign s_ready = (state_reg == lmet_pkg::T_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;

    // launch into the root cell
    assign vld_w[0] = accept && !(s_op == lmet_pkg::OP_QUERY && ood);
    assign idx_w[0] = '0;
    assign tok_w[0] = '{op:    s_op,
                        slope: s_line_slope,
                        icpt:  s_line_intercept,
                        lo:    base_ext,
                        x:     x_ext,
                        best:  lmet_pkg::VAL_MAX};

    for (genvar k = 0; k <= DB; k++) begin : g_level
        lmet_cell #(
            .DB    (DB),
            .LEVEL (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .clr_en   (state_reg == lmet_pkg::T_CLEAR),
            .clr_addr (clr_cnt_reg),
            .in_vld   (vld_w[k]),
            .in_tok   (tok_w[k]),
            .in_idx   (idx_w[k]),
            .out_vld  (vld_w[k+1]),
            .out_tok  (tok_w[k+1]),
            .out_idx  (idx_w[k+1]),
            .done_o   (done_w[k])
        );
    end

    // only one cell finishes a walk, so the reports merge by or
    always_comb begin
        done_any = '0;
        for (int k = 0; k <= DB; k++) begin
            done_any = done_any | (done_w[k] & {$bits(lmet_pkg::lmet_done_t){done_w[k].done}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_base_reg <= '0;
        end else if (cfg_wr_en) begin
            x_base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lmet_pkg::T_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_ood_reg   <= m_ood_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_ood_next   = m_ood_reg;
        unique case (state_reg)
            lmet_pkg::T_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = lmet_pkg::T_IDLE;
                end
            end
            lmet_pkg::T_IDLE: begin
                if (accept) begin
                    if (s_op == lmet_pkg::OP_QUERY && ood) begin
                        m_valid_next = 1'b1;
                        m_value_next = lmet_pkg::FLAT_LEVEL;
                        m_ood_next   = 1'b1;
                    end else begin
                        state_next = lmet_pkg::T_BUSY;
                    end
                end
            end
            lmet_pkg::T_BUSY: begin
                if (done_any.done) begin
                    state_next = lmet_pkg::T_IDLE;
                    if (done_any.query) begin
                        m_valid_next = 1'b1;
                        m_value_next = done_any.best;
                        m_ood_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = lmet_pkg::T_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_min_value     = m_value_reg;
    assign m_out_of_domain = m_ood_reg;

endmodule

[bench/min_line_envelope_tree_unit_tb.sv]
// self-checking testbench for the min line envelope tree unit
`timescale 1ns / 1ps

module min_line_envelope_tree_unit_tb;

    localparam int DBITS     = 10;
    localparam int NODES     = 1 << (DBITS + 1);
    localparam int CYC_LIMIT = 1500000;

    // envelope tree mirror plus queue of expected query answers
    class envelope_board;
        logic signed [31:0] slope_q[NODES];
        logic signed [63:0] icpt_q[NODES];
        bit                 used_q[NODES];
        logic signed [31:0] base;
        logic signed [63:0] want_val[$];
        bit                 want_ood[$];
        int                 errors;

        function new();
            base = 0;
            errors = 0;
            foreach (used_q[i]) begin
                slope_q[i] = 0;
                icpt_q[i] = 0;
                used_q[i] = 0;
            end
            icpt_q[1] = lmet_pkg::FLAT_LEVEL;
            used_q[1] = 1;
        endfunction

        // saturating value of one line at x
        function logic signed [63:0] line_val(logic signed [31:0] s, logic signed [63:0] c,
                                              longint x);
            logic signed [65:0] t;
            t = 66'(longint'(s) * x) + 66'(c);
            if (t > 66'(lmet_pkg::VAL_MAX)) return lmet_pkg::VAL_MAX;
            if (t < 66'(lmet_pkg::VAL_MIN)) return lmet_pkg::VAL_MIN;
            return t[63:0];
        endfunction

        // queue one expected answer
        function void add_expect(logic signed [63:0] v, bit o);
            want_val = {want_val, v};
            want_ood = {want_ood, o};
        endfunction

        // note one accepted item
        function void note_item(logic op, logic signed [31:0] s_in, logic signed [63:0] c_in,
                                logic signed [31:0] qx);
            int unsigned node, child;
            longint lo, len, mid, x;
            logic signed [31:0] s, ts;
            logic signed [63:0] c, tc, best, v;
            bit ll, ml, gl;
            node = 1;
            lo = base;
            s = s_in;
            c = c_in;
            if (op == lmet_pkg::OP_INSERT) begin
                for (int lv = 0; lv <= DBITS; lv++) begin
                    len = 64'sd1 << (DBITS - lv);
                    mid = lo + len / 2;
                    ll = line_val(s, c, lo) < line_val(slope_q[node], icpt_q[node], lo);
                    ml = line_val(s, c, mid) < line_val(slope_q[node], icpt_q[node], mid);
                    if (ml) begin
                        ts = slope_q[node]; tc = icpt_q[node];
                        slope_q[node] = s; icpt_q[node] = c;
                        s = ts; c = tc;
                    end
                    if (len == 1) break;
                    gl = (ll != ml);
                    child = (node << 1) | (gl ? 0 : 1);
                    if (child >= NODES) break;
                    if (!gl) lo = mid;
                    if (!used_q[child]) begin
                        slope_q[child] = s; icpt_q[child] = c; used_q[child] = 1;
                        break;
                    end
                    node = child;
                end
            end else begin
                x = qx;
                if (x < longint'(base) || x > longint'(base) + (64'sd1 << DBITS) - 1) begin
                    add_expect(lmet_pkg::FLAT_LEVEL, 1);
                    return;
                end
                best = line_val(slope_q[1], icpt_q[1], x);
                for (int lv = 0; lv < DBITS; lv++) begin
                    len = 64'sd1 << (DBITS - lv);
                    mid = lo + len / 2;
                    child = (node << 1) | (x < mid ? 0 : 1);
                    if (child >= NODES || !used_q[child]) break;
                    if (x >= mid) lo = mid;
                    node = child;
                    v = line_val(slope_q[node], icpt_q[node], x);
                    if (v < best) best = v;
                end
                add_expect(best, 0);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic signed [63:0] val, logic ood);
            logic signed [63:0] ev;
            bit eo;
            if (want_val.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result val=%0d ood=%0b", val, ood);
                return;
            end
            ev = want_val.pop_front();
            eo = want_ood.pop_front();
            if (ev !== val || eo !== ood) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp val=%0d ood=%0b got val=%0d ood=%0b",
                             ev, eo, val, ood);
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_wr_en = 0;
    logic [31:0]        cfg_wr_data = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_op = 0;
    logic signed [31:0] s_line_slope = 0;
    logic signed [63:0] s_line_intercept = 0;
    logic signed [31:0] s_query_x = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [63:0] m_min_value;
    logic               m_out_of_domain;

    envelope_board board = new();
    int cycles = 0;
    bit rx_idle_ok = 1;

    always #5 aclk = ~aclk;

    min_line_envelope_tree_unit #(.DOMAIN_BITS(DBITS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_line_slope(s_line_slope), .s_line_intercept(s_line_intercept),
        .s_query_x(s_query_x),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_min_value(m_min_value), .m_out_of_domain(m_out_of_domain)
    );

    // watchdog on total cycles
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: handshake seen between edges, random stall per item
    initial begin
        int gap;
        logic signed [63:0] val;
        logic ood;
        forever begin
            @(negedge aclk);
            if (m_valid && m_ready) begin
                val = m_min_value;
                ood = m_out_of_domain;
                @(posedge aclk);
                board.check_result(val, ood);
                gap = rx_idle_ok ? $urandom_range(0, 14) : 0;
                if (gap > 0) begin
                    m_ready <= 0;
                    repeat (gap) @(posedge aclk);
                    m_ready <= 1;
                end
            end else if (!m_ready) begin
                @(posedge aclk);
                m_ready <= 1;
            end
        end
    end

    // present one item and hold it until accepted
    task automatic send_item(logic op, logic signed [31:0] sl, logic signed [63:0] ic,
                             logic signed [31:0] qx, int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_op <= op;
        s_line_slope <= sl;
        s_line_intercept <= ic;
        s_query_x <= qx;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
        board.note_item(op, sl, ic, qx);
    endtask

    // wait for all answers, then let any insert walk finish before a config write
    task automatic drain();
        s_valid <= 0;
        while (board.want_val.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_base(logic signed [31:0] b);
        cfg_wr_en <= 1;
        cfg_wr_data <= b;
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.base = b;
    endtask

    function automatic logic signed [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // query x: mostly inside the domain, sometimes just outside or anywhere
    function automatic logic signed [31:0] pick_x();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return board.base - 1;
        if (r == 2) return board.base + (1 << DBITS);
        return board.base + $urandom_range(0, (1 << DBITS) - 1);
    endfunction

    // mixed random items with modest values so the envelope gets deep
    task automatic random_phase(int n);
        logic signed [31:0] sl;
        logic signed [63:0] ic;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            sl = (r < 7) ? $signed($urandom_range(0, 2000)) - 1000 : $urandom;
            ic = (r < 7) ? 64'(signed'($urandom_range(0, 2000000))) - 1000000 : rnd64();
            send_item(1'($urandom_range(0, 1)), sl, ic, pick_x(),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        // directed: extremes on the default domain
        send_item(lmet_pkg::OP_QUERY, 0, 0, 0, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 1023, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, -1, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 1024, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h8000_0000, 0);
        send_item(lmet_pkg::OP_INSERT, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 5, 0);
        send_item(lmet_pkg::OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 7, 0);
        send_item(lmet_pkg::OP_INSERT, 3, -100, 0, 0);
        send_item(lmet_pkg::OP_INSERT, 3, -100, 0, 0);
        send_item(lmet_pkg::OP_INSERT, -5, 400, 0, 0);
        send_item(lmet_pkg::OP_INSERT, 0, -1, 32'hFFFF_FFFF, 0);
        send_item(lmet_pkg::OP_QUERY, 32'hFFFF_FFFF, -1, 0, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 512, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 1023, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 77, 0);
        drain();
        // base changes with inserts already stored
        set_base(32'h8000_0000);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h8000_0000, 0);
        send_item(lmet_pkg::OP_INSERT, 12, -9, 0, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h8000_0100, 0);
        drain();
        set_base(32'h7FFF_FC00);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF, 0);
        send_item(lmet_pkg::OP_INSERT, -7, 5, 0, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF, 0);
        send_item(lmet_pkg::OP_QUERY, 0, 0, 32'h7FFF_FBFF, 0);
        drain();
        set_base(32'h7FFF_FFFF);
        random_phase(300);
        drain();
        set_base(-500);
        random_phase(500);
        // sender holds off until all answers are in
        s_valid <= 0;
        while (board.want_val.size() != 0) @(posedge aclk);
        @(posedge aclk);
        rx_idle_ok = 0;
        random_phase(300);
        rx_idle_ok = 1;
        drain();
        set_base($urandom);
        random_phase(400);
        drain();
        set_base(0);
        random_phase(400);
        drain();
        if (board.errors == 0 && board.want_val.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
